// File: hdl/set_assoc_lru_writeback_cache_tags_assert.svh
// ---------------------------------------------------------------------------
// set_assoc_lru_writeback_cache_tags assertion macros
// clocked property checks with asynchronous reset disable
// ---------------------------------------------------------------------------
`ifndef SET_ASSOC_LRU_WRITEBACK_CACHE_TAGS_ASSERT_SVH
`define SET_ASSOC_LRU_WRITEBACK_CACHE_TAGS_ASSERT_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge out of reset
`define SAWBC_ASSERT(label, clk_sig, rst_sig, prop) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) \
        else $error("sawbc assertion failed");
// expression must never be true out of reset
`define SAWBC_NEVER(label, clk_sig, rst_sig, expr) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) !(expr)) \
        else $error("sawbc forbidden condition seen");
`else
`define SAWBC_ASSERT(label, clk_sig, rst_sig, prop)
`define SAWBC_NEVER(label, clk_sig, rst_sig, expr)
`endif
`endif

// File: hdl/sawbc_pkg.sv
// ---------------------------------------------------------------------------
// sawbc_pkg
// shared types, codes and field widths of the cache tag store
// ---------------------------------------------------------------------------
package sawbc_pkg;

    // fixed widths of result fields
    localparam int OUTC_W     = 2;
    localparam int SIDX_W     = 8;
    localparam int OFF_W      = 31;
    localparam int WAYO_W     = 3;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int OFFB_W     = 5;
    localparam int IDXB_W     = 4;
    localparam int WAYSB_W    = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

    localparam logic [OFFB_W-1:0]  OFFSET_BITS_RST = 5'd5;
    localparam logic [IDXB_W-1:0]  INDEX_BITS_RST  = 4'd6;
    localparam logic [WAYSB_W-1:0] WAYS_RST        = 4'd8;

    typedef enum logic [OUTC_W-1:0] {
        OUT_HIT        = 2'd0,
        OUT_CLEAN_MISS = 2'd1,
        OUT_DIRTY_MISS = 2'd2
    } outcome_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SPLIT,
        ST_LOOKUP,
        ST_SCAN,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic start;
        logic step;
    } scan_ctl_t;

    typedef struct packed {
        logic match;
        logic hit;
        logic found_inv;
    } scan_stat_t;

endpackage

// File: hdl/sawbc_if.sv
// ---------------------------------------------------------------------------
// sawbc channel interfaces
// request, result and configuration write channels with valid/ready
// ---------------------------------------------------------------------------
interface sawbc_req_if #(
    parameter int ADDR_W  = 32,
    parameter int STAMP_W = 32
);
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [ADDR_W-1:0]  address;
    logic [STAMP_W-1:0] stamp;

    modport source (output valid, output req_type, output address, output stamp,
                    input ready);
    modport sink   (input valid, input req_type, input address, input stamp,
                    output ready);
endinterface

interface sawbc_res_if #(
    parameter int ADDR_W  = 32,
    parameter int STAMP_W = 32
);
    logic                           valid;
    logic                           ready;
    logic [sawbc_pkg::OUTC_W-1:0]   outcome;
    logic [sawbc_pkg::SIDX_W-1:0]   set_index;
    logic [ADDR_W-1:0]              line_tag;
    logic [sawbc_pkg::OFF_W-1:0]    block_offset;
    logic [sawbc_pkg::WAYO_W-1:0]   way_used;
    logic [STAMP_W-1:0]             previous_stamp;

    modport source (output valid, output outcome, output set_index, output line_tag,
                    output block_offset, output way_used, output previous_stamp,
                    input ready);
    modport sink   (input valid, input outcome, input set_index, input line_tag,
                    input block_offset, input way_used, input previous_stamp,
                    output ready);
endinterface

interface sawbc_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [sawbc_pkg::CFG_IDX_W-1:0]   index;
    logic [sawbc_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/sawbc_ram.sv
// ---------------------------------------------------------------------------
// sawbc_ram
// single write port, single registered read port memory
// ---------------------------------------------------------------------------
module sawbc_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // read data holds until the next read
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hdl/sawbc_scan.sv
// ---------------------------------------------------------------------------
// sawbc_scan
// shared way compare unit: tag match and lru victim tracking, one way a cycle
// ---------------------------------------------------------------------------
module sawbc_scan #(
    parameter int MAX_WAYS = 8,
    parameter int ADDR_W   = 32,
    parameter int STAMP_W  = 32,
    localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  sawbc_pkg::scan_ctl_t    ctl,
    input  logic [WAY_W-1:0]        way,
    input  logic [MAX_WAYS-1:0]     row_valid,
    input  logic [ADDR_W-1:0]       tag_in,
    input  logic [ADDR_W-1:0]       line_tag,
    input  logic [STAMP_W-1:0]      line_stamp,
    output sawbc_pkg::scan_stat_t   stat,
    output logic [WAY_W-1:0]        sel_way,
    output logic [STAMP_W-1:0]      prev_stamp
);

    logic               hit_reg;
    logic               hit_next;
    logic               found_inv_reg;
    logic               found_inv_next;
    logic [WAY_W-1:0]   sel_way_reg;
    logic [WAY_W-1:0]   sel_way_next;
    logic [STAMP_W-1:0] best_reg;
    logic [STAMP_W-1:0] best_next;
    logic [STAMP_W-1:0] prev_reg;
    logic [STAMP_W-1:0] prev_next;
    logic               cur_valid;
    logic               match;

    assign cur_valid = row_valid[way];
    assign match     = cur_valid && (line_tag == tag_in);

    always_comb
    begin
        hit_next       = hit_reg;
        found_inv_next = found_inv_reg;
        sel_way_next   = sel_way_reg;
        best_next      = best_reg;
        prev_next      = prev_reg;
        if (ctl.start)
        begin
            hit_next       = 1'b0;
            found_inv_next = 1'b0;
            prev_next      = '0;
        end
        else if (ctl.step)
        begin
            if (match)
            begin
                hit_next     = 1'b1;
                sel_way_next = way;
                prev_next    = line_stamp;
            end
            else if (!found_inv_reg)
            begin
                // first free way wins, else oldest stamp with first way on ties
                if (!cur_valid)
                begin
                    found_inv_next = 1'b1;
                    sel_way_next   = way;
                end
                else if ((way == '0) || (line_stamp < best_reg))
                begin
                    best_next    = line_stamp;
                    sel_way_next = way;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg       <= 1'b0;
            found_inv_reg <= 1'b0;
        end
        else
        begin
            hit_reg       <= hit_next;
            found_inv_reg <= found_inv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_way_reg <= sel_way_next;
        best_reg    <= best_next;
        prev_reg    <= prev_next;
    end

    assign stat.match     = match;
    assign stat.hit       = hit_reg;
    assign stat.found_inv = found_inv_reg;
    assign sel_way        = sel_way_reg;
    assign prev_stamp     = prev_reg;

endmodule

// File: hdl/set_assoc_lru_writeback_cache_tags.sv
// ---------------------------------------------------------------------------
// set_assoc_lru_writeback_cache_tags
// tag store of a set-associative write-back cache with stamp-based lru
// ---------------------------------------------------------------------------
// channel  dir  handshake    payload
// cfg      in   valid/ready  index, data
// req      in   valid/ready  req_type, address, stamp
// res      out  valid/ready  outcome, set_index, line_tag, block_offset,
//                            way_used, previous_stamp
//
// an access passes the split, lookup, scan and write states before the next acceptance; the scan
// compares the ways one per cycle: up to the first hit, else every way in use (1 to MAX_WAYS)
// after reset a clearing pass writes one valid/dirty row a cycle over all 2**floor(log2
// MAX_SETS) rows (256 by default) before requests are taken; cfg is always ready
// a waiting result does not stop the next request being taken; its write-back then
// holds until the result register is free
// ---------------------------------------------------------------------------
`include "set_assoc_lru_writeback_cache_tags_assert.svh"

module set_assoc_lru_writeback_cache_tags #(
    parameter int MAX_SETS    = 256,
    parameter int MAX_WAYS    = 8,
    parameter int ADDR_WIDTH  = 32,
    parameter int STAMP_WIDTH = 32
) (
    input  logic     clk,
    input  logic     rst_n,
    sawbc_cfg_if.sink   cfg,
    sawbc_req_if.sink   req,
    sawbc_res_if.source res
);

    localparam int IB_MAX = $clog2(MAX_SETS + 1) - 1;
    localparam int ROWS   = 1 << IB_MAX;
    localparam int SET_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCNT_W = $clog2(MAX_WAYS + 1);
    localparam int CMP_W  = WCNT_W + 1;
    localparam int LINES  = ROWS * MAX_WAYS;
    localparam int LINE_W = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int LDAT_W = ADDR_WIDTH + STAMP_WIDTH;
    localparam logic [sawbc_pkg::IDXB_W-1:0] IB_MAX_C = sawbc_pkg::IDXB_W'(IB_MAX);

    // configuration
    logic [sawbc_pkg::OFFB_W-1:0]  offset_bits_reg;
    logic [sawbc_pkg::IDXB_W-1:0]  index_bits_reg;
    logic [sawbc_pkg::WAYSB_W-1:0] ways_reg;
    logic [sawbc_pkg::IDXB_W-1:0]  ib_eff;
    logic [WCNT_W-1:0]             ways_eff;

    // sequencer
    sawbc_pkg::state_t state_reg;
    sawbc_pkg::state_t state_next;
    logic [SET_W-1:0]  clr_reg;
    logic [SET_W-1:0]  clr_next;
    logic [WAY_W-1:0]  way_reg;
    logic [WAY_W-1:0]  way_next;
    logic [WAY_W-1:0]  rd_way;
    logic              last_way;
    logic              accept;
    logic              load_res;

    // request and split fields
    logic                        req_type_reg;
    logic [ADDR_WIDTH-1:0]       addr_reg;
    logic [ADDR_WIDTH-1:0]       upper_reg;
    logic [STAMP_WIDTH-1:0]      stamp_reg;
    logic [sawbc_pkg::OFF_W-1:0] offset_reg;
    logic [SET_W-1:0]            set_reg;
    logic [ADDR_WIDTH-1:0]       tag_reg;
    logic [ADDR_WIDTH-1:0]       off_full;
    logic [ADDR_WIDTH-1:0]       set_full;

    // memories
    logic                  row_wr_en;
    logic [SET_W-1:0]      row_wr_addr;
    logic [2*MAX_WAYS-1:0] row_wr_data;
    logic                  row_rd_en;
    logic [2*MAX_WAYS-1:0] row_q;
    logic [MAX_WAYS-1:0]   valid_row;
    logic [MAX_WAYS-1:0]   dirty_row;
    logic [MAX_WAYS-1:0]   way_mask;
    logic [MAX_WAYS-1:0]   wr_mask;
    logic [MAX_WAYS-1:0]   valid_upd;
    logic [MAX_WAYS-1:0]   dirty_upd;
    logic                  line_wr_en;
    logic                  line_rd_en;
    logic [LINE_W-1:0]     line_base;
    logic [LINE_W-1:0]     line_rd_addr;
    logic [LINE_W-1:0]     line_wr_addr;
    logic [LDAT_W-1:0]     line_q;

    // compare unit
    sawbc_pkg::scan_ctl_t  scan_ctl;
    sawbc_pkg::scan_stat_t scan_stat;
    logic [WAY_W-1:0]      sel_way;
    logic [STAMP_WIDTH-1:0] prev_stamp;

    // result register
    logic                          res_valid_reg;
    logic                          res_valid_next;
    sawbc_pkg::outcome_t           outcome_reg;
    sawbc_pkg::outcome_t           outcome_new;
    logic [sawbc_pkg::SIDX_W-1:0]  set_out_reg;
    logic [ADDR_WIDTH-1:0]         tag_out_reg;
    logic [sawbc_pkg::OFF_W-1:0]   off_out_reg;
    logic [sawbc_pkg::WAYO_W-1:0]  way_out_reg;
    logic [STAMP_WIDTH-1:0]        prev_out_reg;

    // ---------------------------------------------------------------- config
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bits_reg <= sawbc_pkg::OFFSET_BITS_RST;
            index_bits_reg  <= sawbc_pkg::INDEX_BITS_RST;
            ways_reg        <= sawbc_pkg::WAYS_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                sawbc_pkg::CFG_OFFSET_BITS: offset_bits_reg <= sawbc_pkg::OFFB_W'(cfg.data);
                sawbc_pkg::CFG_INDEX_BITS:  index_bits_reg  <= sawbc_pkg::IDXB_W'(cfg.data);
                sawbc_pkg::CFG_WAYS_IN_USE: ways_reg        <= sawbc_pkg::WAYSB_W'(cfg.data);
                default: ;
            endcase
        end
    end

    // index width saturates at floor(log2 MAX_SETS), ways clamp to 1..MAX_WAYS
    assign ib_eff = (index_bits_reg > IB_MAX_C) ? IB_MAX_C : index_bits_reg;

    always_comb
    begin
        if (ways_reg == '0)
        begin
            ways_eff = WCNT_W'(1);
        end
        else if ({1'b0, ways_reg} > (sawbc_pkg::WAYSB_W + 1)'(MAX_WAYS))
        begin
            ways_eff = WCNT_W'(MAX_WAYS);
        end
        else
        begin
            ways_eff = WCNT_W'(ways_reg);
        end
    end

    // ---------------------------------------------------------------- split
    assign accept    = req.valid && req.ready;
    assign off_full  = addr_reg & ~({ADDR_WIDTH{1'b1}} << offset_bits_reg);
    assign set_full  = upper_reg & ~({ADDR_WIDTH{1'b1}} << ib_eff);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_type_reg <= req.req_type;
            addr_reg     <= req.address;
            upper_reg    <= req.address >> offset_bits_reg;
            stamp_reg    <= req.stamp;
        end
        if (state_reg == sawbc_pkg::ST_SPLIT)
        begin
            offset_reg <= sawbc_pkg::OFF_W'(off_full);
            set_reg    <= SET_W'(set_full);
            tag_reg    <= upper_reg >> ib_eff;
        end
    end

    // ---------------------------------------------------------------- memories
    assign valid_row    = row_q[MAX_WAYS-1:0];
    assign dirty_row    = row_q[2*MAX_WAYS-1:MAX_WAYS];
    assign way_mask     = MAX_WAYS'(1) << sel_way;
    assign wr_mask      = req_type_reg ? way_mask : '0;
    assign valid_upd    = valid_row | way_mask;
    assign dirty_upd    = scan_stat.hit ? (dirty_row | wr_mask)
                                        : ((dirty_row & ~way_mask) | wr_mask);
    assign line_base    = LINE_W'(set_reg) * LINE_W'(MAX_WAYS);
    assign line_rd_addr = line_base + LINE_W'(rd_way);
    assign line_wr_addr = line_base + LINE_W'(sel_way);

    sawbc_ram #(
        .DEPTH (ROWS),
        .WIDTH (2 * MAX_WAYS)
    ) u_row_ram (
        .clk     (clk),
        .wr_en   (row_wr_en),
        .wr_addr (row_wr_addr),
        .wr_data (row_wr_data),
        .rd_en   (row_rd_en),
        .rd_addr (set_reg),
        .rd_data (row_q)
    );

    sawbc_ram #(
        .DEPTH (LINES),
        .WIDTH (LDAT_W)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (line_wr_en),
        .wr_addr (line_wr_addr),
        .wr_data ({tag_reg, stamp_reg}),
        .rd_en   (line_rd_en),
        .rd_addr (line_rd_addr),
        .rd_data (line_q)
    );

    sawbc_scan #(
        .MAX_WAYS (MAX_WAYS),
        .ADDR_W   (ADDR_WIDTH),
        .STAMP_W  (STAMP_WIDTH)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (scan_ctl),
        .way        (way_reg),
        .row_valid  (valid_row),
        .tag_in     (tag_reg),
        .line_tag   (line_q[LDAT_W-1:STAMP_WIDTH]),
        .line_stamp (line_q[STAMP_WIDTH-1:0]),
        .stat       (scan_stat),
        .sel_way    (sel_way),
        .prev_stamp (prev_stamp)
    );

    // ---------------------------------------------------------------- sequencer
    assign last_way = ((CMP_W'(way_reg) + CMP_W'(1)) == CMP_W'(ways_eff));
    assign req.ready = (state_reg == sawbc_pkg::ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        way_next    = way_reg;
        rd_way      = '0;
        row_wr_en   = 1'b0;
        row_wr_addr = set_reg;
        row_wr_data = {dirty_upd, valid_upd};
        row_rd_en   = 1'b0;
        line_wr_en  = 1'b0;
        line_rd_en  = 1'b0;
        scan_ctl    = '0;
        load_res    = 1'b0;
        case (state_reg)
            sawbc_pkg::ST_CLEAR:
            begin
                row_wr_en   = 1'b1;
                row_wr_addr = clr_reg;
                row_wr_data = '0;
                if (clr_reg == SET_W'(ROWS - 1))
                begin
                    state_next = sawbc_pkg::ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            sawbc_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = sawbc_pkg::ST_SPLIT;
                end
            end
            sawbc_pkg::ST_SPLIT:
            begin
                state_next = sawbc_pkg::ST_LOOKUP;
            end
            sawbc_pkg::ST_LOOKUP:
            begin
                row_rd_en      = 1'b1;
                line_rd_en     = 1'b1;
                scan_ctl.start = 1'b1;
                way_next       = '0;
                state_next     = sawbc_pkg::ST_SCAN;
            end
            sawbc_pkg::ST_SCAN:
            begin
                // compare this way while fetching the next one
                scan_ctl.step = 1'b1;
                line_rd_en    = 1'b1;
                rd_way        = way_reg + 1'b1;
                if (scan_stat.match || last_way)
                begin
                    state_next = sawbc_pkg::ST_WRITE;
                end
                else
                begin
                    way_next = way_reg + 1'b1;
                end
            end
            sawbc_pkg::ST_WRITE:
            begin
                if (!res_valid_reg || res.ready)
                begin
                    row_wr_en  = 1'b1;
                    line_wr_en = 1'b1;
                    load_res   = 1'b1;
                    state_next = sawbc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sawbc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sawbc_pkg::ST_CLEAR;
            clr_reg       <= '0;
            way_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            way_reg       <= way_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // ---------------------------------------------------------------- result
    always_comb
    begin
        if (scan_stat.hit)
        begin
            outcome_new = sawbc_pkg::OUT_HIT;
        end
        else if (!scan_stat.found_inv && dirty_row[sel_way])
        begin
            outcome_new = sawbc_pkg::OUT_DIRTY_MISS;
        end
        else
        begin
            outcome_new = sawbc_pkg::OUT_CLEAN_MISS;
        end
    end

    assign res_valid_next = load_res ? 1'b1 : (res_valid_reg && !res.ready);

    always_ff @(posedge clk)
    begin
        if (load_res)
        begin
            outcome_reg  <= outcome_new;
            set_out_reg  <= sawbc_pkg::SIDX_W'(set_reg);
            tag_out_reg  <= tag_reg;
            off_out_reg  <= offset_reg;
            way_out_reg  <= sawbc_pkg::WAYO_W'(sel_way);
            prev_out_reg <= prev_stamp;
        end
    end

    assign res.valid          = res_valid_reg;
    assign res.outcome        = outcome_reg;
    assign res.set_index      = set_out_reg;
    assign res.line_tag       = tag_out_reg;
    assign res.block_offset   = off_out_reg;
    assign res.way_used       = way_out_reg;
    assign res.previous_stamp = prev_out_reg;

    // ---------------------------------------------------------------- checks
    `SAWBC_ASSERT(a_accept_starts_split, clk, rst_n, accept |=> state_reg == sawbc_pkg::ST_SPLIT)
    `SAWBC_ASSERT(a_result_from_write, clk, rst_n, $rose(res_valid_reg) |-> $past(state_reg == sawbc_pkg::ST_WRITE))
    `SAWBC_ASSERT(a_scan_in_range, clk, rst_n, (state_reg == sawbc_pkg::ST_SCAN) |-> (CMP_W'(way_reg) < CMP_W'(ways_eff)))
    `SAWBC_NEVER(a_miss_no_stamp, clk, rst_n, res_valid_reg && (outcome_reg != sawbc_pkg::OUT_HIT) && (prev_out_reg != '0))

endmodule
